@@ hdl/zoom_pan_register_calc_macros.svh @@
// Assertion macros for the zoom/pan register calculator.
// Included by the top level; no other dependencies.
`ifndef ZOOM_PAN_REGISTER_CALC_MACROS_SVH
`define ZOOM_PAN_REGISTER_CALC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/zpr_pkg.sv @@
// Shared types, constants and codes for the zoom/pan register calculator.
// No dependencies; imported by the controller, datapath and top level.
package zpr_pkg;

    localparam int ORIGIN_BITS_DEF = 20;
    localparam int COORD_W         = 15;
    localparam int DIM_W           = 11;
    localparam int ZC_W            = 4;
    localparam int Z_W             = ZC_W + 1;
    localparam int DELTA_W         = 16;
    localparam int POS_W           = DELTA_W + 1;
    localparam int PROD_W          = COORD_W + DIM_W;
    localparam int CNT_W           = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COORD_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd1152;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd909;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_PAN = 1'b1;

    // Upper bound on offset plus zoom-weighted nibble term, per zoom code.
    localparam logic [6:0] LEGAL_LIMIT [16] = '{
        7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70, 7'd70,
        7'd70, 7'd69, 7'd71, 7'd71, 7'd71, 7'd66, 7'd69, 7'd72
    };

    typedef struct packed {
        logic                      command;
        logic [COORD_W-1:0]        origin_x;
        logic [COORD_W-1:0]        origin_y;
        logic [ZC_W-1:0]           zoom_code;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        registers_written;
        logic [15:0] word_pan;
        logic [7:0]  pixel_pan;
        logic [7:0]  zoom_register;
        logic        offset_error;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL   = 6'b001000,
        S_SUM   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic check;
        logic div_step;
        logic mul;
        logic sum;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic pan_ok;
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

endpackage

@@ hdl/zoom_pan_register_calc.sv @@
// Top level of the zoom/pan register calculator: controller plus datapath.
// Depends on zpr_pkg, zpr_ctrl, zpr_dpath and the assertion macro header.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes a set command
//   (absolute origin and zoom code) or a pan command (signed deltas).
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per command: accepted flag, registers-written flag, word pan,
//   pixel pan, zoom register and offset error.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes screen width (index 0) or height (index 1); ready is always high.
//   Write configuration only while no command is in flight.
// Sequencing:
//   A command passes through the bound check, a bit-serial divide of the origin
//   by the zoom factor, multiply, sum and finish before o_out_valid; a
//   rejected pan goes from the check straight to finish. No new command is
//   taken until the result of the last one is loaded and the controller is idle.
//   When the receiver stalls, the result holds in the output register; the
//   next command is still accepted and runs up to its own result, then waits.
// Reset (synchronous, active low): screen 1152 x 909, stored origin and zoom
//   zero, no result pending.
`include "zoom_pan_register_calc_macros.svh"

module zoom_pan_register_calc #(
    parameter int ORIGIN_BITS = zpr_pkg::ORIGIN_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  zpr_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output zpr_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [zpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [zpr_pkg::DIM_W-1:0]      i_cfg_data
);
    import zpr_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    assign o_cfg_ready = 1'b1;

    zpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    zpr_dpath #(
        .ORIGIN_BITS (ORIGIN_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    `ZPR_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall,
        "input taken while previous command still in flight")
    `ZPR_ASSERT_SAME(a_written_implies_accepted, i_clk, i_rst_n,
        o_out_valid && o_out_data.registers_written, o_out_data.accepted,
        "registers written for a rejected pan")
    `ZPR_ASSERT_SAME(a_reject_is_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.accepted,
        (o_out_data.word_pan == '0) && (o_out_data.pixel_pan == '0)
            && (o_out_data.zoom_register == '0) && !o_out_data.offset_error,
        "rejected pan carries nonzero fields")
    `ZPR_ASSERT_SAME(a_idle_on_new_result, i_clk, i_rst_n,
        $rose(o_out_valid), !o_in_stall,
        "controller not idle after loading a result")

endmodule

@@ hdl/zpr_ctrl.sv @@
// Sequencer for the zoom/pan register calculator: accept, bound check,
// divide, multiply, sum, finish. Depends on zpr_pkg.
module zpr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zpr_pkg::t_ctrl_sts  i_sts,
    output zpr_pkg::t_ctrl_cmd  o_cmd
);
    import zpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                // a rejected pan skips straight to the result
                n_state = i_sts.pan_ok ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hdl/zpr_dpath.sv @@
// Datapath for the zoom/pan register calculator: screen registers, stored
// origin and zoom, two restoring dividers, multiplier, walk and legality.
// Depends on zpr_pkg.
module zpr_dpath #(
    parameter int ORIGIN_BITS = zpr_pkg::ORIGIN_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  zpr_pkg::t_in_item                  i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [zpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [zpr_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output zpr_pkg::t_out_item                 o_out_data,
    input  zpr_pkg::t_ctrl_cmd                 i_cmd,
    output zpr_pkg::t_ctrl_sts                 o_sts
);
    import zpr_pkg::*;

    // configuration and architectural state
    logic [DIM_W-1:0]       r_width;
    logic [DIM_W-1:0]       r_height;
    logic [COORD_W-1:0]     r_cur_x;
    logic [COORD_W-1:0]     r_cur_y;
    logic [ZC_W-1:0]        r_cur_zc;

    // per-item working registers
    logic                   r_pan;
    logic [ZC_W-1:0]        r_zc;
    logic [POS_W-1:0]       r_nx;
    logic [POS_W-1:0]       r_ny;
    logic                   r_ok;
    logic [COORD_W-1:0]     r_qx;
    logic [COORD_W-1:0]     r_qy;
    logic [ZC_W-1:0]        r_rx;
    logic [ZC_W-1:0]        r_ry;
    logic [CNT_W-1:0]       r_cnt;
    logic [PROD_W-1:0]      r_prod;
    logic [ORIGIN_BITS-1:0] r_org;
    logic [2:0]             r_steps;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic [Z_W-1:0]         w_z;
    logic [15:0]            w_bound_x;
    logic [15:0]            w_bound_y;
    logic                   w_pan_ok;
    logic                   w_pan;
    logic [POS_W-1:0]       w_nx;
    logic [POS_W-1:0]       w_ny;
    logic [Z_W-1:0]         w_tx;
    logic [Z_W-1:0]         w_ty;
    logic                   w_bx;
    logic                   w_by;
    logic [ZC_W-1:0]        w_h;
    logic [2:0]             w_steps;
    logic [1:0]             w_lsb;
    logic [PROD_W:0]        w_sum;
    logic [7:0]             w_walk;
    logic [4:0]             w_poff;
    logic [7:0]             w_chk;
    logic                   w_legal;
    logic [ORIGIN_BITS+15:0] w_org_ext;
    logic [ZC_W-1:0]        w_voff;
    t_out_item              w_res;
    logic                   w_out_free;

    assign w_z = {1'b0, r_zc} + Z_W'(1);

    // bounds for a pan: screen size times zoom factor
    assign w_bound_x = 16'(r_width) * 16'(w_z);
    assign w_bound_y = 16'(r_height) * 16'(w_z);
    assign w_pan_ok  = !r_pan
                     || (!r_nx[POS_W-1] && (r_nx[15:0] < w_bound_x)
                         && !r_ny[POS_W-1] && (r_ny[15:0] < w_bound_y));

    // new position for the incoming item
    assign w_pan = (i_in_data.command == CMD_PAN);
    assign w_nx  = w_pan ? ({2'b00, r_cur_x} + {i_in_data.delta_x[DELTA_W-1], i_in_data.delta_x})
                         : {2'b00, i_in_data.origin_x};
    assign w_ny  = w_pan ? ({2'b00, r_cur_y} + {i_in_data.delta_y[DELTA_W-1], i_in_data.delta_y})
                         : {2'b00, i_in_data.origin_y};

    // one restoring-division bit per cycle for x and y
    assign w_tx = {r_rx, r_qx[COORD_W-1]};
    assign w_ty = {r_ry, r_qy[COORD_W-1]};
    assign w_bx = (w_tx >= w_z);
    assign w_by = (w_ty >= w_z);

    // phosphor granularity: backward walk length for odd zooms and
    // even zooms that are not a multiple of four
    assign w_h = w_z[0] ? r_rx : {r_rx[ZC_W-1:1], 1'b0};

    always_comb begin
        w_steps = 3'd4;
        w_lsb   = 2'b00;
        if ((w_z[1:0] == 2'b00) || (w_z == Z_W'(2))) begin
            w_steps = 3'd0;
        end else begin
            for (int s = 3; s >= 0; s--) begin
                w_lsb = 2'(s) * w_z[1:0] + w_h[1:0];
                if (w_lsb == 2'b00) begin
                    w_steps = 3'(s);
                end
            end
        end
    end

    assign w_sum = {1'b0, r_prod} + (PROD_W + 1)'(r_qx);

    // offset, legality and register values
    assign w_walk = 8'(r_steps) * 8'(w_z) + 8'(w_h);

    always_comb begin
        if (w_z[1:0] == 2'b00) begin
            w_poff = ({1'b0, r_rx} + 5'd1) >> 2;
        end else if (w_z == Z_W'(2)) begin
            w_poff = 5'd0;
        end else begin
            w_poff = w_walk[6:2];
        end
    end

    assign w_chk     = 8'(w_poff) + 8'(w_z) * 8'(3'd3 + {1'b0, r_org[3:2]});
    assign w_legal   = (w_chk <= {1'b0, LEGAL_LIMIT[r_zc]});
    assign w_org_ext = {16'b0, r_org};
    assign w_voff    = r_zc - r_ry;

    always_comb begin
        w_res = '0;
        if (r_ok) begin
            w_res.accepted     = 1'b1;
            w_res.offset_error = w_poff[4];
            if (w_legal) begin
                w_res.registers_written = 1'b1;
                w_res.word_pan          = w_org_ext[19:4];
                w_res.pixel_pan         = {r_org[3:0], 4'b0000} + 8'(w_poff);
                w_res.zoom_register     = {w_voff, r_zc};
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_zc    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish && r_ok) begin
                r_cur_x <= r_nx[COORD_W-1:0];
                r_cur_y <= r_ny[COORD_W-1:0];
                if (w_legal) begin
                    r_cur_zc <= r_zc;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pan <= w_pan;
            r_zc  <= w_pan ? r_cur_zc : i_in_data.zoom_code;
            r_nx  <= w_nx;
            r_ny  <= w_ny;
        end
        if (i_cmd.check) begin
            r_ok  <= w_pan_ok;
            r_qx  <= r_nx[COORD_W-1:0];
            r_qy  <= r_ny[COORD_W-1:0];
            r_rx  <= '0;
            r_ry  <= '0;
            r_cnt <= DIV_LAST;
        end
        if (i_cmd.div_step) begin
            r_rx  <= w_bx ? ZC_W'(w_tx - w_z) : w_tx[ZC_W-1:0];
            r_ry  <= w_by ? ZC_W'(w_ty - w_z) : w_ty[ZC_W-1:0];
            r_qx  <= {r_qx[COORD_W-2:0], w_bx};
            r_qy  <= {r_qy[COORD_W-2:0], w_by};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_qy) * PROD_W'(r_width);
        end
        if (i_cmd.sum) begin
            // the walk wraps modulo the origin width
            r_org   <= w_sum[ORIGIN_BITS-1:0] - ORIGIN_BITS'(w_steps);
            r_steps <= w_steps;
        end
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_sts.pan_ok   = w_pan_ok;
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ tb/zpr_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the zoom/pan register calculator: snoops the command,
// result and register-write channels, predicts each result and compares it.
// Depends on zpr_pkg for the channel structs, command codes and register indexes.
module zpr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  zpr_pkg::t_in_item             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  zpr_pkg::t_out_item            i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [zpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [zpr_pkg::DIM_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_results_due
);
    import zpr_pkg::*;

    localparam int ORIGIN_W = ORIGIN_BITS_DEF;

    // Highest allowed phosphor offset plus weighted nibble term, by zoom code.
    localparam int LIMIT_BY_ZOOM [16] = '{
        70, 70, 70, 70, 70, 70, 70, 70, 70, 69, 71, 71, 71, 66, 69, 72
    };

    logic [DIM_W-1:0] scr_width;
    logic [DIM_W-1:0] scr_height;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic [ZC_W-1:0]  zoom_now;
    t_out_item        pan_regs_due[$];
    t_out_item        due_regs;
    int               mismatches = 0;

    // Work out the register values for origin (x, y) at zoom code zc.
    function automatic t_out_item calc_registers(int x, int y, logic [ZC_W-1:0] zc);
        int                  z;
        int                  hoff;
        int                  voff;
        int                  poff;
        int                  steps;
        int                  chk;
        logic [ORIGIN_W-1:0] org;
        t_out_item           r;
        z     = int'(zc) + 1;
        org   = ORIGIN_W'(longint'(y / z) * longint'(scr_width) + longint'(x / z));
        hoff  = x % z;
        voff  = z - 1 - y % z;
        pos_x = 16'(x);
        pos_y = 16'(y);
        if (z % 4 == 0) begin
            poff = (hoff + 1) / 4;
        end else if (z == 2) begin
            poff = 0;
        end else begin
            // step the origin back one pixel at a time until phosphor-aligned
            if (z % 2 == 0) begin
                hoff = hoff & 'hFE;
            end
            steps = 0;
            while ((steps * z + hoff) % 4 != 0 && steps < 4) begin
                steps++;
                org = org - 1'b1;
            end
            poff = (steps * z + hoff) / 4;
        end
        r              = '0;
        r.accepted     = 1'b1;
        r.offset_error = (poff > 15);
        chk = poff + z * (3 + int'(org[3:0]) / 4);
        if (chk <= LIMIT_BY_ZOOM[z - 1]) begin
            r.registers_written = 1'b1;
            r.word_pan          = 16'(org >> 4);
            r.pixel_pan         = 8'(int'(org[3:0]) * 16 + poff);
            r.zoom_register     = 8'(voff * 16 + z - 1);
            zoom_now            = zc;
        end
        return r;
    endfunction

    function automatic t_out_item predict_cmd(t_in_item c);
        int z;
        int nx;
        int ny;
        if (c.command == CMD_SET) begin
            return calc_registers(int'(c.origin_x), int'(c.origin_y), c.zoom_code);
        end
        z  = int'(zoom_now) + 1;
        nx = int'(pos_x) + int'($signed(c.delta_x));
        ny = int'(pos_y) + int'($signed(c.delta_y));
        // out-of-window pan: all-zero result, origin kept
        if (nx < 0 || nx >= int'(scr_width) * z || ny < 0 || ny >= int'(scr_height) * z) begin
            return '0;
        end
        return calc_registers(nx, ny, zoom_now);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_width  = WIDTH_RESET;
            scr_height = HEIGHT_RESET;
            pos_x      = '0;
            pos_y      = '0;
            zoom_now   = '0;
            pan_regs_due.delete();
        end else begin
            // retire results before queueing this edge's command
            if (i_out_valid && !i_out_stall) begin
                if (pan_regs_due.size() == 0) begin
                    $display("%0t: result with nothing pending: %p", $time, i_out_data);
                    mismatches++;
                end else begin
                    due_regs = pan_regs_due.pop_front();
                    if (i_out_data !== due_regs) begin
                        $display({"%0t: result mismatch\n",
                                  "  expected acc=%b wr=%b word_pan=%h pixel_pan=%h ",
                                  "zoom_reg=%h off_err=%b\n",
                                  "  actual   acc=%b wr=%b word_pan=%h pixel_pan=%h ",
                                  "zoom_reg=%h off_err=%b"},
                                 $time,
                                 due_regs.accepted, due_regs.registers_written,
                                 due_regs.word_pan, due_regs.pixel_pan,
                                 due_regs.zoom_register, due_regs.offset_error,
                                 i_out_data.accepted, i_out_data.registers_written,
                                 i_out_data.word_pan, i_out_data.pixel_pan,
                                 i_out_data.zoom_register, i_out_data.offset_error);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  scr_width = i_cfg_data;
                    CFG_SCREEN_HEIGHT: scr_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pan_regs_due.push_back(predict_cmd(i_in_data));
            end
        end
        o_fail_count  <= mismatches;
        o_results_due <= pan_regs_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the zoom/pan register calculator: clock, reset, command
// and register-write stimulus, random result stalls, and the final verdict.
// Depends on zpr_pkg, zoom_pan_register_calc and zpr_checker.
module tb;
    import zpr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int NUM_PHASES     = 7;
    localparam int RANDOM_PHASE   = 5;
    localparam int SPARE_PHASE    = 3;
    localparam int CMDS_PER_PHASE = 236;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;

    localparam int SCREEN_W [NUM_PHASES] = '{640, 2047, 1, 0, 1152, 1, 1152};
    localparam int SCREEN_H [NUM_PHASES] = '{480, 2047, 1, 909, 0, 1, 909};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   results_due;
    int                   hold_tok;

    // stimulus-side view of the screen and origin, used to aim pans
    int scr_w = 1152;
    int scr_h = 909;
    int trk_x = 0;
    int trk_y = 0;
    int trk_zc = 0;

    zoom_pan_register_calc DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    zpr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result-side stall: mostly short bursts, a few long ones, and one long
    // hold-off per phase so the block backs up into its command input.
    initial begin : out_stall_gen
        int hold_seen;
        int sel;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            sel = $urandom_range(0, 99);
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sel < 35) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else if (sel < 85) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else if (sel < 97) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(5, 25)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end
        end
    end

    function automatic t_in_item mk_cmd(logic cmd, int ox, int oy, int zc, int dx, int dy);
        t_in_item c;
        c.command   = cmd;
        c.origin_x  = COORD_W'(ox);
        c.origin_y  = COORD_W'(oy);
        c.zoom_code = ZC_W'(zc);
        c.delta_x   = DELTA_W'(dx);
        c.delta_y   = DELTA_W'(dy);
        return c;
    endfunction

    function automatic int pick_in(int lim);
        if (lim <= 0) begin
            return 0;
        end
        return $urandom_range(0, ((lim > 32768) ? 32768 : lim) - 1);
    endfunction

    // Pan step toward a nearby spot, a random in-window spot, or a window edge.
    function automatic logic [DELTA_W-1:0] aim_delta(int pos, int lim);
        int tgt;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: tgt = pos + int'($urandom_range(0, 64)) - 32;
            6, 7:             tgt = pick_in(lim);
            8:                tgt = ($urandom_range(0, 1) != 0) ? 0 : -1;
            default:          tgt = ($urandom_range(0, 1) != 0) ? lim - 1 : lim;
        endcase
        return DELTA_W'(tgt - pos);
    endfunction

    task automatic build_cmd(output t_in_item c);
        int sel;
        int lim_x;
        int lim_y;
        int nx;
        int ny;
        c.origin_x  = COORD_W'($urandom);
        c.origin_y  = COORD_W'($urandom);
        c.zoom_code = ZC_W'($urandom);
        c.delta_x   = DELTA_W'($urandom);
        c.delta_y   = DELTA_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            c.command = CMD_SET;
            lim_x = scr_w * (int'(c.zoom_code) + 1);
            lim_y = scr_h * (int'(c.zoom_code) + 1);
            if ($urandom_range(0, 3) != 0) begin
                c.origin_x = COORD_W'(pick_in(lim_x));
                c.origin_y = COORD_W'(pick_in(lim_y));
            end
            trk_x  = int'(c.origin_x);
            trk_y  = int'(c.origin_y);
            trk_zc = int'(c.zoom_code);
        end else begin
            c.command = CMD_PAN;
            lim_x = scr_w * (trk_zc + 1);
            lim_y = scr_h * (trk_zc + 1);
            // most pans aimed, the rest raw deltas
            if (sel < 88) begin
                c.delta_x = aim_delta(trk_x, lim_x);
                c.delta_y = aim_delta(trk_y, lim_y);
            end
            nx = trk_x + int'($signed(c.delta_x));
            ny = trk_y + int'($signed(c.delta_y));
            if (nx >= 0 && nx < lim_x && ny >= 0 && ny < lim_y) begin
                trk_x = nx;
                trk_y = ny;
            end
        end
    endtask

    // Offer one command after a random gap and hold it until the transfer.
    task automatic send_cmd(t_in_item c);
        int sel;
        int gap;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            gap = 0;
        end else if (sel < 85) begin
            gap = $urandom_range(1, 5);
        end else if (sel < 97) begin
            gap = $urandom_range(6, 30);
        end else begin
            gap = $urandom_range(31, 100);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_in_item c;
        int       w;
        int       h;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SCREEN_WIDTH;
        i_cfg_data  = '0;
        hold_tok    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset screen size, field extremes, offset walk, window edges
        send_cmd(mk_cmd(CMD_SET, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(CMD_SET, 32767, 32767, 15, 32767, -32768));
        send_cmd(mk_cmd(CMD_SET, 1, 0, 2, 0, 0));        // walk wraps origin to all ones
        send_cmd(mk_cmd(CMD_SET, 5, 7, 13, 0, 0));
        send_cmd(mk_cmd(CMD_SET, 3, 3, 1, 0, 0));
        send_cmd(mk_cmd(CMD_SET, 3, 9, 3, 0, 0));
        send_cmd(mk_cmd(CMD_SET, 7, 2, 9, 0, 0));
        send_cmd(mk_cmd(CMD_SET, 200, 0, 15, 0, 0));     // illegal combination
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 3, 1));        // pan at the zoom still in force
        send_cmd(mk_cmd(CMD_SET, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, -1, 0));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 0, -1));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 1151, 908));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 1, 0));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 0, 1));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, -1151, -908));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, -32768, 32767));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 32767, -32768));
        send_cmd(mk_cmd(CMD_PAN, 32767, 32767, 15, 5, 5));
        send_cmd(mk_cmd(CMD_SET, 0, 0, 15, 0, 0));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 18431, 14543));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 1, 0));
        send_cmd(mk_cmd(CMD_PAN, 0, 0, 0, 0, 1));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            w = SCREEN_W[ph];
            h = SCREEN_H[ph];
            if (ph == RANDOM_PHASE) begin
                w = $urandom_range(1, 2047);
                h = $urandom_range(1, 2047);
            end
            drain();
            write_reg(CFG_SCREEN_WIDTH, DIM_W'(w));
            write_reg(CFG_SCREEN_HEIGHT, DIM_W'(h));
            if (ph == SPARE_PHASE) begin
                // writes to unused indexes must leave the screen size alone
                write_reg(CFG_SPARE_A, DIM_W'($urandom));
                write_reg(CFG_SPARE_B, DIM_W'($urandom));
            end
            i_cfg_valid <= 1'b0;
            scr_w = w;
            scr_h = h;
            hold_tok <= hold_tok + 1;
            repeat (CMDS_PER_PHASE) begin
                build_cmd(c);
                send_cmd(c);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
